>>> hdl/paged_kv_slot_mapper_unit_assert.svh
// Assertion macros used by the checker file of the slot mapper.
`ifndef PAGED_KV_SLOT_MAPPER_UNIT_ASSERT_SVH
`define PAGED_KV_SLOT_MAPPER_UNIT_ASSERT_SVH

// Clocked check, quiet while reset is held
`define PKVSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles
`define PKVSM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pkvsm_pkg.sv
`default_nettype none
package pkvsm_pkg;

  localparam int DEF_MAX_TABLE_ENTRIES = 256;
  localparam int DEF_MAX_SEQS          = 256;

  localparam int BS_W       = 9;
  localparam int NB_W       = 16;
  localparam int POS_W      = 16;
  localparam int TID_W      = 20;
  localparam int CNT_W      = 24;
  localparam int KEY_W      = 17;
  localparam int SEQI_W     = 8;
  localparam int STAT_W     = 4;
  localparam int PROD_W     = 25;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 200;
  localparam int REQ_W      = 2;

  localparam logic [CFG_AW-1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_NUM_BLOCKS = 2'd1;
  localparam logic [BS_W-1:0]   BS_RESET       = 9'd16;
  localparam logic [CNT_W:0]    CNT_LIMIT      = 25'h0FF_FFFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_BATCH  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SEQ    = 2'd2,
    REQ_TOKEN  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK           = 4'd0,
    STS_NOT_ALLOC    = 4'd1,
    STS_BAD_BLOCK    = 4'd2,
    STS_ZERO_TOKENS  = 4'd3,
    STS_SLICE_RANGE  = 4'd4,
    STS_NO_TABLE     = 4'd5,
    STS_TABLE_SMALL  = 4'd6,
    STS_SLOT_RANGE   = 4'd7,
    STS_EMPTY_DECODE = 4'd8,
    STS_OVERFLOW     = 4'd9
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic rd_issue;
    logic mul_load;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_t req;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/pkvsm_ram.sv
`default_nettype none
module pkvsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hdl/pkvsm_ctrl.sv
`default_nettype none
module pkvsm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire pkvsm_pkg::req_t  in_req,
  output logic                  in_tready,
  input  wire pkvsm_pkg::sts_t  sts,
  output pkvsm_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Sequence the work of one transaction
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_req)
            pkvsm_pkg::REQ_TOKEN: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            pkvsm_pkg::REQ_SEQ: state_nxt = S_MUL;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/pkvsm_dpath.sv
`default_nettype none
module pkvsm_dpath #(
  parameter int MAX_TABLE_ENTRIES = pkvsm_pkg::DEF_MAX_TABLE_ENTRIES,
  parameter int MAX_SEQS          = pkvsm_pkg::DEF_MAX_SEQS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [pkvsm_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire logic [pkvsm_pkg::CFG_DW-1:0]       cfg_wdata,
  input  wire logic [pkvsm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire pkvsm_pkg::req_t                    in_req,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [pkvsm_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  input  wire pkvsm_pkg::cmd_t                    cmd,
  output pkvsm_pkg::sts_t                         sts
);

  localparam int TL_W = $clog2(MAX_TABLE_ENTRIES + 1);
  localparam int AW   = (MAX_TABLE_ENTRIES > 1) ? $clog2(MAX_TABLE_ENTRIES) : 1;
  localparam int SC_W = $clog2(MAX_SEQS + 1);
  localparam int BS_W = pkvsm_pkg::BS_W;
  localparam int NB_W = pkvsm_pkg::NB_W;
  localparam int PW   = pkvsm_pkg::POS_W;
  localparam int CW   = pkvsm_pkg::CNT_W;

  // Configuration
  logic [BS_W-1:0] block_size_r;
  logic [NB_W-1:0] num_blocks_r;

  // Batch state
  logic [TL_W-1:0] table_len_r, table_len_nxt;
  logic            prefill_r, prefill_nxt;
  logic [SC_W-1:0] seq_cnt_r, seq_cnt_nxt;
  logic [PW-1:0]   next_pos_r, next_pos_nxt;
  logic [PW-1:0]   slice_end_r, slice_end_nxt;
  logic [CW-1:0]   cum_q_r, cum_q_nxt;
  logic [CW-1:0]   cum_k_r, cum_k_nxt;
  logic [PW-1:0]   max_q_r, max_q_nxt;
  logic [PW-1:0]   max_k_r, max_k_nxt;

  // Latched transaction
  pkvsm_pkg::req_t           req_r;
  logic                      in_prefill_r;
  logic [NB_W-1:0]           blk_r;
  logic [PW-1:0]             start_r;
  logic [PW-1:0]             sched_r;
  logic [PW-1:0]             total_r;
  logic [pkvsm_pkg::TID_W-1:0] tok_r;

  // Divider, product, output
  logic [PW-1:0]                  quot_r;
  logic [BS_W-1:0]                rem_r;
  logic [4:0]                     div_cnt_r;
  logic [pkvsm_pkg::PROD_W-1:0]   prod_r;
  logic                           out_valid_r;
  logic [pkvsm_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [BS_W-1:0] bs_eff;
  logic [BS_W:0]   trial;
  logic            trial_ge;
  logic [16:0]     idx_full;
  logic            idx_ok;
  logic [NB_W-1:0] ram_rdata;
  logic [NB_W-1:0] mul_a;
  logic            ram_we;

  assign bs_eff = (block_size_r == '0) ? BS_W'(1) : block_size_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= pkvsm_pkg::BS_RESET;
      num_blocks_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        pkvsm_pkg::CFG_BLOCK_SIZE: block_size_r <= cfg_wdata[BS_W-1:0];
        pkvsm_pkg::CFG_NUM_BLOCKS: num_blocks_r <= cfg_wdata[NB_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_req;
      in_prefill_r <= in_tdata[0];
      blk_r        <= in_tdata[16:1];
      start_r      <= in_tdata[32:17];
      sched_r      <= in_tdata[48:33];
      total_r      <= in_tdata[64:49];
      tok_r        <= in_tdata[84:65];
    end
  end

  // Restoring divider: position over block size, one quotient bit a cycle
  assign trial    = {rem_r, quot_r[PW-1]};
  assign trial_ge = (trial >= {1'b0, bs_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= 5'(PW);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot_r <= next_pos_r;
      rem_r  <= '0;
    end else if (div_cnt_r != '0) begin
      quot_r <= {quot_r[PW-2:0], trial_ge};
      rem_r  <= trial_ge ? BS_W'(trial - {1'b0, bs_eff}) : trial[BS_W-1:0];
    end
  end

  // Table index: block of the position in prefill, last entry in decode
  always_comb begin
    if (prefill_r) begin
      idx_full = {1'b0, quot_r};
    end else begin
      idx_full = 17'(table_len_r) - 17'd1;
    end
    idx_ok = (idx_full < 17'(table_len_r));
  end

  pkvsm_ram #(
    .WIDTH (NB_W),
    .DEPTH (MAX_TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (table_len_r[AW-1:0]),
    .wdata (blk_r),
    .re    (cmd.rd_issue),
    .raddr (idx_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared multiplier: table size times block size, or block id times block size
  assign mul_a = (req_r == pkvsm_pkg::REQ_TOKEN) ? ram_rdata : NB_W'(table_len_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= pkvsm_pkg::PROD_W'(mul_a) * pkvsm_pkg::PROD_W'(bs_eff);
    end
  end

  // Result and next batch state
  always_comb begin
    logic [16:0]                  seq_end;
    logic [CW:0]                  cq_sum;
    logic [CW:0]                  ck_sum;
    logic [pkvsm_pkg::PROD_W-1:0] slot_sum;
    logic [CW-1:0]                seq_m1;
    logic [CW-1:0]                last_idx;
    pkvsm_pkg::status_t           status;
    logic [CW-1:0]                slot;
    logic [PW-1:0]                position;
    logic [pkvsm_pkg::KEY_W-1:0]  key_len;
    logic [pkvsm_pkg::SEQI_W-1:0] seq_index;
    logic [pkvsm_pkg::TID_W-1:0]  token_out;
    logic                         fin;

    table_len_nxt = table_len_r;
    prefill_nxt   = prefill_r;
    seq_cnt_nxt   = seq_cnt_r;
    next_pos_nxt  = next_pos_r;
    slice_end_nxt = slice_end_r;
    cum_q_nxt     = cum_q_r;
    cum_k_nxt     = cum_k_r;
    max_q_nxt     = max_q_r;
    max_k_nxt     = max_k_r;
    ram_we        = 1'b0;
    status        = pkvsm_pkg::STS_OK;
    slot          = '0;
    position      = '0;
    key_len       = '0;
    seq_index     = '0;
    token_out     = '0;
    fin           = 1'b0;
    seq_end       = 17'(start_r) + 17'(sched_r);
    cq_sum        = {1'b0, cum_q_r} + (CW+1)'(sched_r);
    ck_sum        = {1'b0, cum_k_r} + (CW+1)'(seq_end);
    slot_sum      = prod_r + pkvsm_pkg::PROD_W'(rem_r);
    seq_m1        = CW'(seq_cnt_r) - CW'(1);

    case (req_r)
      pkvsm_pkg::REQ_BATCH: begin
        prefill_nxt   = in_prefill_r;
        table_len_nxt = '0;
        seq_cnt_nxt   = '0;
        next_pos_nxt  = '0;
        slice_end_nxt = '0;
        cum_q_nxt     = '0;
        cum_k_nxt     = '0;
        max_q_nxt     = '0;
        max_k_nxt     = '0;
      end
      pkvsm_pkg::REQ_APPEND: begin
        if (table_len_r >= TL_W'(MAX_TABLE_ENTRIES)) begin
          status = pkvsm_pkg::STS_OVERFLOW;
        end else if (num_blocks_r == '0) begin
          status = pkvsm_pkg::STS_NOT_ALLOC;
        end else if (blk_r >= num_blocks_r) begin
          status = pkvsm_pkg::STS_BAD_BLOCK;
        end else begin
          ram_we        = cmd.finish;
          table_len_nxt = table_len_r + TL_W'(1);
        end
      end
      pkvsm_pkg::REQ_SEQ: begin
        next_pos_nxt  = '0;
        slice_end_nxt = '0;
        if (seq_cnt_r >= SC_W'(MAX_SEQS)) begin
          status = pkvsm_pkg::STS_OVERFLOW;
        end else if (prefill_r) begin
          if (sched_r == '0) begin
            status = pkvsm_pkg::STS_ZERO_TOKENS;
          end else if (seq_end > 17'(total_r)) begin
            status = pkvsm_pkg::STS_SLICE_RANGE;
          end else if (table_len_r == '0) begin
            status = pkvsm_pkg::STS_NO_TABLE;
          end else if (prod_r < pkvsm_pkg::PROD_W'(seq_end)) begin
            status = pkvsm_pkg::STS_TABLE_SMALL;
          end else if (cq_sum > pkvsm_pkg::CNT_LIMIT || ck_sum > pkvsm_pkg::CNT_LIMIT) begin
            status = pkvsm_pkg::STS_OVERFLOW;
          end else begin
            next_pos_nxt  = start_r;
            slice_end_nxt = seq_end[PW-1:0];
            cum_q_nxt     = cq_sum[CW-1:0];
            cum_k_nxt     = ck_sum[CW-1:0];
            if (sched_r > max_q_r) max_q_nxt = sched_r;
            if (seq_end[PW-1:0] > max_k_r) max_k_nxt = seq_end[PW-1:0];
            seq_cnt_nxt   = seq_cnt_r + SC_W'(1);
          end
        end else begin
          if (total_r == '0) begin
            status = pkvsm_pkg::STS_EMPTY_DECODE;
          end else if (table_len_r == '0) begin
            status = pkvsm_pkg::STS_NO_TABLE;
          end else if (prod_r < pkvsm_pkg::PROD_W'(total_r)) begin
            status = pkvsm_pkg::STS_TABLE_SMALL;
          end else begin
            next_pos_nxt  = total_r - PW'(1);
            slice_end_nxt = total_r;
            seq_cnt_nxt   = seq_cnt_r + SC_W'(1);
          end
        end
      end
      default: begin
        if (next_pos_r >= slice_end_r) begin
          status = pkvsm_pkg::STS_SLICE_RANGE;
        end else begin
          fin = (17'(next_pos_r) + 17'd1 == 17'(slice_end_r));
          // Map the position through the table
          if (!prefill_r && table_len_r == '0) begin
            status = pkvsm_pkg::STS_NO_TABLE;
          end else if (!idx_ok) begin
            status = pkvsm_pkg::STS_TABLE_SMALL;
          end else if (num_blocks_r == '0) begin
            status = pkvsm_pkg::STS_NOT_ALLOC;
          end else if (ram_rdata >= num_blocks_r) begin
            status = pkvsm_pkg::STS_BAD_BLOCK;
          end else if (slot_sum > pkvsm_pkg::CNT_LIMIT) begin
            status = pkvsm_pkg::STS_SLOT_RANGE;
          end else begin
            slot = slot_sum[CW-1:0];
          end
          position     = next_pos_r;
          key_len      = 17'(next_pos_r) + 17'd1;
          seq_index    = seq_m1[pkvsm_pkg::SEQI_W-1:0];
          token_out    = tok_r;
          next_pos_nxt = next_pos_r + PW'(1);
          if (fin) table_len_nxt = '0;
        end
      end
    endcase

    if (prefill_nxt) begin
      last_idx = (cum_q_nxt != '0) ? (cum_q_nxt - CW'(1)) : '0;
    end else begin
      last_idx = (seq_cnt_nxt != '0) ? (CW'(seq_cnt_nxt) - CW'(1)) : '0;
    end

    out_data_nxt = {7'd0, max_k_nxt, max_q_nxt, last_idx, cum_k_nxt, cum_q_nxt,
                    token_out, seq_index, key_len, position, slot, status};
    out_last_nxt = fin;
  end

  // Commit batch state at the end of a transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_len_r <= '0;
      prefill_r   <= 1'b0;
      seq_cnt_r   <= '0;
      next_pos_r  <= '0;
      slice_end_r <= '0;
      cum_q_r     <= '0;
      cum_k_r     <= '0;
      max_q_r     <= '0;
      max_k_r     <= '0;
    end else if (cmd.finish) begin
      table_len_r <= table_len_nxt;
      prefill_r   <= prefill_nxt;
      seq_cnt_r   <= seq_cnt_nxt;
      next_pos_r  <= next_pos_nxt;
      slice_end_r <= slice_end_nxt;
      cum_q_r     <= cum_q_nxt;
      cum_k_r     <= cum_k_nxt;
      max_q_r     <= max_q_nxt;
      max_k_r     <= max_k_nxt;
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign sts.req      = req_r;
  assign sts.div_done = (div_cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule
`default_nettype wire

>>> hdl/paged_kv_slot_mapper_unit.sv
`default_nettype none
// Paged KV-cache slot mapper. Each input transaction (selected by in_tuser: begin batch,
// append table entry, begin sequence, token) yields exactly one result transaction.
// Begin batch and append go from acceptance straight to the result step, begin sequence
// first takes one registered multiply of table size by block size, and a token takes a
// bit-serial divide of the position by the block size (16 quotient bits plus the done
// check), one read of the block table RAM, one registered multiply of the block id by
// the block size and the result step. A result that is not taken holds the block in its
// last cycle until out_tready rises. A new transaction is accepted while the previous
// result still waits in the output register. out_tlast marks the final token of a
// sequence. No clearing pass follows reset.
module paged_kv_slot_mapper_unit #(
  parameter int MAX_TABLE_ENTRIES = pkvsm_pkg::DEF_MAX_TABLE_ENTRIES,
  parameter int MAX_SEQS          = pkvsm_pkg::DEF_MAX_SEQS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [pkvsm_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire logic [pkvsm_pkg::CFG_DW-1:0]       cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // batch mode flag, kv block number, cached_tokens, scheduled_tokens, total_tokens,
  // token_id
  input  wire logic [pkvsm_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type
  input  wire logic [pkvsm_pkg::REQ_W-1:0]        in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // status, slot, position, key_len, seq_index, token_out, cum_query_len,
  // cum_key_len, last_index, max_query_len, max_key_len
  output logic [pkvsm_pkg::OUT_DATA_W-1:0]        out_tdata,
  // final_token
  output logic                                    out_tlast
);

  pkvsm_pkg::cmd_t cmd;
  pkvsm_pkg::sts_t sts;
  pkvsm_pkg::req_t in_req;

  assign in_req = pkvsm_pkg::req_t'(in_tuser);

  pkvsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_req),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pkvsm_dpath #(
    .MAX_TABLE_ENTRIES (MAX_TABLE_ENTRIES),
    .MAX_SEQS          (MAX_SEQS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_req     (in_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

>>> hdl/pkvsm_checker.sv
`default_nettype none
`include "paged_kv_slot_mapper_unit_assert.svh"
module pkvsm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [pkvsm_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);

  // Stalled result holds
  `PKVSM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Block is busy right after taking a transaction
  `PKVSM_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted back to back")

  // Failed mapping never reports a slot
  `PKVSM_ASSERT(a_slot_zero_on_error, out_tvalid && out_tdata[3:0] != pkvsm_pkg::STS_OK |-> out_tdata[27:4] == 24'd0, "slot set on error")

  // Reset leaves no result and an idle input side
  `PKVSM_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

endmodule

bind paged_kv_slot_mapper_unit pkvsm_checker u_pkvsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

>>> sim/paged_kv_slot_mapper_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module paged_kv_slot_mapper_checker
  import pkvsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [REQ_W-1:0]      in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  out_tlast,
  output int                         fail_count,
  output int                         pending_count
);

  localparam int TABLE_DEPTH = DEF_MAX_TABLE_ENTRIES;
  localparam int SEQ_LIMIT   = DEF_MAX_SEQS;
  localparam longint unsigned MASK24 = 64'hFF_FFFF;

  typedef struct {
    logic [3:0]  status;
    logic [23:0] slot;
    logic [15:0] position;
    logic [16:0] key_len;
    logic [7:0]  seq_index;
    logic [19:0] token_out;
    logic [23:0] cum_query;
    logic [23:0] cum_key;
    logic [23:0] last_index;
    logic [15:0] max_query;
    logic [15:0] max_key;
    logic        final_token;
  } mapping_t;

  // Shadow of the block state and registers
  logic [15:0]  blk_table [TABLE_DEPTH];
  int unsigned  tbl_len, prefill_mode, seq_cnt, next_pos, slice_end;
  int unsigned  cum_q, cum_k, max_q, max_k;
  int unsigned  blk_size, num_blks;

  mapping_t     mapping_q[$];
  int           mismatches;

  function automatic int unsigned eff_bs();
    return (blk_size == 0) ? 1 : blk_size;
  endfunction

  // Translate a table index and position into a cache slot
  function automatic status_t lookup_slot(input int unsigned idx, input int unsigned pos,
                                          output int unsigned slot);
    longint unsigned blk, s;
    int unsigned bs;
    bs = eff_bs();
    slot = 0;
    if (idx >= tbl_len || idx >= TABLE_DEPTH) return STS_TABLE_SMALL;
    blk = blk_table[idx];
    if (num_blks == 0) return STS_NOT_ALLOC;
    if (blk >= num_blks) return STS_BAD_BLOCK;
    s = blk * bs + (pos % bs);
    if (s >= longint'(num_blks) * bs || s > MASK24) return STS_SLOT_RANGE;
    slot = int'(s);
    return STS_OK;
  endfunction

  function automatic mapping_t compute_mapping(input req_t req, input logic [IN_DATA_W-1:0] d);
    mapping_t    r;
    status_t     st;
    int unsigned bs, start, q, total, fin_pos, p, slot, idx;
    bit          fin;
    r = '{default: '0};
    st = STS_OK;
    bs = eff_bs();
    case (req)
      REQ_BATCH: begin
        prefill_mode = d[0];
        tbl_len = 0; seq_cnt = 0; next_pos = 0; slice_end = 0;
        cum_q = 0; cum_k = 0; max_q = 0; max_k = 0;
      end
      REQ_APPEND: begin
        if (tbl_len >= TABLE_DEPTH) st = STS_OVERFLOW;
        else if (num_blks == 0) st = STS_NOT_ALLOC;
        else if (d[16:1] >= num_blks) st = STS_BAD_BLOCK;
        else begin
          blk_table[tbl_len] = d[16:1];
          tbl_len++;
        end
      end
      REQ_SEQ: begin
        start = d[32:17];
        q = d[48:33];
        total = d[64:49];
        next_pos = 0; slice_end = 0;
        if (seq_cnt >= SEQ_LIMIT) st = STS_OVERFLOW;
        else if (prefill_mode != 0) begin
          fin_pos = start + q;
          if (q == 0) st = STS_ZERO_TOKENS;
          else if (fin_pos > total) st = STS_SLICE_RANGE;
          else if (tbl_len == 0) st = STS_NO_TABLE;
          else if (tbl_len < (fin_pos + bs - 1) / bs) st = STS_TABLE_SMALL;
          else if (cum_q + q > MASK24 || cum_k + fin_pos > MASK24) st = STS_OVERFLOW;
          else begin
            next_pos = start; slice_end = fin_pos;
            cum_q += q; cum_k += fin_pos;
            if (q > max_q) max_q = q;
            if (fin_pos > max_k) max_k = fin_pos;
            seq_cnt++;
          end
        end else begin
          if (total == 0) st = STS_EMPTY_DECODE;
          else if (tbl_len == 0) st = STS_NO_TABLE;
          else if (tbl_len < (total + bs - 1) / bs) st = STS_TABLE_SMALL;
          else begin
            next_pos = total - 1; slice_end = total;
            seq_cnt++;
          end
        end
      end
      default: begin
        if (next_pos >= slice_end) st = STS_SLICE_RANGE;
        else begin
          p = next_pos;
          slot = 0;
          fin = (p + 1 == slice_end);
          if (prefill_mode != 0) begin
            idx = p / bs;
            st = lookup_slot(idx, p, slot);
          end else if (tbl_len == 0) begin
            st = STS_NO_TABLE;
          end else begin
            idx = tbl_len - 1;
            st = lookup_slot(idx, p, slot);
          end
          r.slot = (st == STS_OK) ? slot[23:0] : '0;
          r.position = p[15:0];
          r.key_len = 17'(p + 1);
          r.seq_index = 8'(seq_cnt - 1);
          r.token_out = d[84:65];
          r.final_token = fin;
          next_pos = p + 1;
          if (fin) tbl_len = 0;
        end
      end
    endcase
    r.status = st;
    r.cum_query = cum_q[23:0];
    r.cum_key = cum_k[23:0];
    if (prefill_mode != 0) r.last_index = (cum_q != 0) ? 24'(cum_q - 1) : '0;
    else r.last_index = (seq_cnt != 0) ? 24'(seq_cnt - 1) : '0;
    r.max_query = max_q[15:0];
    r.max_key = max_k[15:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      fail_count++;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    mismatches = 0;
  end

  // Track register writes, predict on input transactions, compare on output ones
  always @(posedge clk) begin
    mapping_t e;
    if (!rst_n) begin
      tbl_len = 0; prefill_mode = 0; seq_cnt = 0; next_pos = 0; slice_end = 0;
      cum_q = 0; cum_k = 0; max_q = 0; max_k = 0;
      blk_size = BS_RESET; num_blks = 0;
      mapping_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_BLOCK_SIZE) blk_size = cfg_wdata[BS_W-1:0];
        else if (cfg_addr == CFG_NUM_BLOCKS) num_blks = cfg_wdata[NB_W-1:0];
      end
      if (in_tvalid && in_tready)
        mapping_q.insert(mapping_q.size(), compute_mapping(req_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        if (mapping_q.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10) $display("%0t result with no transaction pending", $realtime);
        end else begin
          e = mapping_q.pop_front();
          check_field("status", e.status, out_tdata[3:0]);
          check_field("slot", e.slot, out_tdata[27:4]);
          check_field("position", e.position, out_tdata[43:28]);
          check_field("key_len", e.key_len, out_tdata[60:44]);
          check_field("seq_index", e.seq_index, out_tdata[68:61]);
          check_field("token_out", e.token_out, out_tdata[88:69]);
          check_field("cum_query_len", e.cum_query, out_tdata[112:89]);
          check_field("cum_key_len", e.cum_key, out_tdata[136:113]);
          check_field("last_index", e.last_index, out_tdata[160:137]);
          check_field("max_query_len", e.max_query, out_tdata[176:161]);
          check_field("max_key_len", e.max_key, out_tdata[192:177]);
          check_field("final_token", e.final_token, out_tlast);
        end
      end
    end
    pending_count <= mapping_q.size();
  end

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pkvsm_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 30;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr = '0;
  logic [CFG_DW-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  int                    fail_count, pending_count;
  bit                    calm = 1'b0;
  int                    items_sent = 0;
  int                    stall_cycles = 0;
  int unsigned           cur_bs = 16, cur_nb = 0;

  always #5 clk = ~clk;

  paged_kv_slot_mapper_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  paged_kv_slot_mapper_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver back-pressure
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 32);

  // Stop on a long stretch without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_n && stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // in_tdata: batch mode flag, kv block, cached, scheduled, total, token id (low bit up)
  function automatic logic [IN_DATA_W-1:0] pack_req(input bit pf, input logic [15:0] bid,
      input logic [15:0] cached, input logic [15:0] sched, input logic [15:0] total,
      input logic [19:0] tok);
    return {3'b0, tok, total, sched, cached, bid, pf};
  endfunction

  task automatic send(input req_t req, input logic [IN_DATA_W-1:0] d);
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic batch(input bit pf);
    send(REQ_BATCH, pack_req(pf, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 20'($urandom)));
  endtask

  task automatic append(input logic [15:0] bid);
    send(REQ_APPEND, pack_req(1'($urandom), bid, 16'($urandom), 16'($urandom),
                              16'($urandom), 20'($urandom)));
  endtask

  task automatic sequence_item(input logic [15:0] cached, input logic [15:0] sched,
                               input logic [15:0] total);
    send(REQ_SEQ, pack_req(1'($urandom), 16'($urandom), cached, sched, total,
                           20'($urandom)));
  endtask

  task automatic token(input logic [19:0] tok);
    send(REQ_TOKEN, pack_req(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), tok));
  endtask

  // Drain the block, then write both registers
  task automatic set_cfg(input int unsigned bs, input int unsigned nb);
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_BLOCK_SIZE;
    cfg_wdata <= CFG_DW'(bs);
    @(posedge clk);
    cfg_addr <= CFG_NUM_BLOCKS;
    cfg_wdata <= CFG_DW'(nb);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_bs = bs;
    cur_nb = nb;
  endtask

  // Fill the table past its end, then exceed the sequence count
  task automatic push_limits();
    batch(1'b0);
    repeat (DEF_MAX_TABLE_ENTRIES + 2) append(16'($urandom_range(cur_nb - 1)));
    repeat (DEF_MAX_SEQS + 2)
      sequence_item(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
  endtask

  // Well-formed batches with random content, mixed with noise
  task automatic run_random(input int n);
    int stop_at, nseq, k, bs, span, fin_pos, q, total;
    bit pf;
    bs = (cur_bs == 0) ? 1 : cur_bs;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        send(req_t'($urandom_range(3)), {3'b0, 85'({$urandom, $urandom, $urandom})});
      end else begin
        pf = 1'($urandom_range(1));
        batch(pf);
        nseq = $urandom_range(1, 3);
        repeat (nseq) begin
          k = $urandom_range(1, 4);
          repeat (k) append(16'($urandom_range(cur_nb - 1)));
          span = k * bs;
          if (span > 65535) span = 65535;
          if (pf) begin
            fin_pos = $urandom_range(1, span);
            q = $urandom_range(1, (fin_pos < 5) ? fin_pos : 5);
            total = fin_pos + $urandom_range(3);
            if (total > 65535) total = 65535;
            sequence_item(16'(fin_pos - q), 16'(q), 16'(total));
            if ($urandom_range(99) < 6) q = $urandom_range(q);
            repeat (q) token(20'($urandom));
          end else begin
            sequence_item(16'($urandom), 16'($urandom), 16'($urandom_range(1, span)));
            token(20'($urandom));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: cache not allocated, empty decode, no table, stray token
    append(16'd0);
    token(20'd0);
    batch(1'b0);
    sequence_item(16'd0, 16'd0, 16'd0);
    sequence_item(16'hFFFF, 16'hFFFF, 16'd5);
    set_cfg(16, 100);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_UNUSED;
    cfg_wdata <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    // Prefill: zero tokens, slice range, no table, bad block, table small, good slice
    batch(1'b1);
    sequence_item(16'd0, 16'd0, 16'd10);
    sequence_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
    sequence_item(16'd0, 16'd4, 16'd4);
    append(16'd0);
    append(16'd99);
    append(16'd100);
    append(16'hFFFF);
    sequence_item(16'd30, 16'd10, 16'd40);
    sequence_item(16'd30, 16'd2, 16'd40);
    token(20'hFFFFF);
    token(20'd0);
    token(20'h5A5A5);
    // Block rechecked per token after a register change
    append(16'd50);
    append(16'd60);
    sequence_item(16'd0, 16'd18, 16'd18);
    set_cfg(16, 55);
    token(20'd1);
    set_cfg(16, 0);
    token(20'd2);
    // Zero block size, then slot beyond 24 bits
    set_cfg(0, 65535);
    batch(1'b0);
    append(16'hFFFF);
    sequence_item(16'd0, 16'd0, 16'd1);
    token(20'd3);
    set_cfg(511, 65535);
    batch(1'b1);
    append(16'hFFFF);
    sequence_item(16'd0, 16'd1, 16'd1);
    token(20'd4);

    set_cfg(256, 65535);
    push_limits();

    set_cfg(1, 65535);
    run_random(190);
    set_cfg(256, 65535);
    run_random(190);
    set_cfg(16, 100);
    calm = 1'b1;
    run_random(190);
    calm = 1'b0;
    set_cfg(0, 5);
    run_random(190);
    set_cfg(7, 300);
    run_random(190);
    set_cfg(256, 1);
    run_random(190);
    set_cfg(3, 65535);
    run_random(190);

    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
